### rtl/escu_pkg.sv
// ---------------------------------------------------------------------------
// escu_pkg
// Shared types, register codes and arithmetic helpers for the environmental
// sensor compensation pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package escu_pkg;

    // Depth of the restoring divider, one quotient bit per stage
    localparam int unsigned DIV_STAGES = 64;

    // Configuration register indexes (byte address = 8 * index)
    localparam logic [2:0] REG_TEMP_CAL  = 3'd0;
    localparam logic [2:0] REG_PRESS_LOW = 3'd1;
    localparam logic [2:0] REG_PRESS_HIGH = 3'd2;
    localparam logic [2:0] REG_PRESS_LAST = 3'd3;
    localparam logic [2:0] REG_HUM_CAL   = 3'd4;
    localparam logic [2:0] REG_HUM_MID   = 3'd5;

    // Partial products of a 64 x 64 product kept modulo 2^64
    typedef struct packed {
        logic [63:0] ll;
        logic [31:0] cr;
    } mul_part_t;

    // Results that ride alongside the division
    typedef struct packed {
        logic [31:0] temp;
        logic [16:0] hum;
        logic        neg;
        logic        invalid;
    } div_side_t;

    function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned s);
        return $signed(x) >>> s;
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned s);
        return $signed(x) >>> s;
    endfunction

    // First half of a wrapping 64-bit product: three 32 x 32 multipliers
    function automatic mul_part_t mul_part(input logic [63:0] a, input logic [63:0] b);
        mul_part_t   r;
        logic [31:0] hl;
        logic [31:0] lh;
        r.ll = {32'd0, a[31:0]} * {32'd0, b[31:0]};
        hl   = a[63:32] * b[31:0];
        lh   = a[31:0] * b[63:32];
        r.cr = hl + lh;
        return r;
    endfunction

    function automatic logic [63:0] mul_join(input mul_part_t p);
        return p.ll + {p.cr, 32'd0};
    endfunction

    // Exact signed 34 x 16 product, sign-extended to 64 bits
    function automatic logic [63:0] mul_s34x16(input logic [33:0] a, input logic [15:0] b);
        logic signed [63:0] r;
        r = $signed(a) * $signed(b);
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/escu_div.sv
// ---------------------------------------------------------------------------
// escu_div
// Pipelined unsigned restoring divider, 64-bit dividend by 31-bit divisor,
// one quotient bit per stage, with side payload carried alongside.
// ---------------------------------------------------------------------------
`default_nettype none

module escu_div
    import escu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire logic [63:0] in_num,
    input  wire logic [30:0] in_den,
    input  wire div_side_t   in_side,
    output logic             out_valid,
    output logic [63:0]      out_quo,
    output div_side_t        out_side
);

    logic        v_reg    [DIV_STAGES];
    logic [63:0] q_reg    [DIV_STAGES];
    logic [30:0] rem_reg  [DIV_STAGES];
    logic [30:0] den_reg  [DIV_STAGES];
    div_side_t   side_reg [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        logic        v_in;
        logic [63:0] q_in;
        logic [30:0] rem_in;
        logic [30:0] den_in;
        div_side_t   side_in;
        logic [31:0] trial;
        logic        ge;

        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign q_in    = in_num;
            assign rem_in  = '0;
            assign den_in  = in_den;
            assign side_in = in_side;
        end
        else
        begin : g_rest
            assign v_in    = v_reg[k-1];
            assign q_in    = q_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // shift in the next dividend bit, subtract where it fits
        assign trial = {rem_in, q_in[63]};
        assign ge    = (trial >= {1'b0, den_in});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k]    <= {q_in[62:0], ge};
                rem_reg[k]  <= ge ? 31'(trial - {1'b0, den_in}) : trial[30:0];
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[DIV_STAGES-1];
    assign out_quo   = q_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

### rtl/environmental_sensor_compensation_unit.sv
// ---------------------------------------------------------------------------
// environmental_sensor_compensation_unit
// Integer compensation of raw temperature, pressure and humidity samples.
// ---------------------------------------------------------------------------
// One sample triple per transaction in, one compensated result per
// transaction out. The unit takes a new sample every clock cycle while
// s_tready is high; the pipeline depth is set by the 64-stage restoring
// divider of the pressure path (one quotient bit per stage), plus 15 front
// stages of 32 x 32 multiplier slices and 5 stages after the division. A
// two-entry output (register plus skid) lets the pipe keep moving while a
// result waits; s_tready drops only once the skid entry is occupied.
// Calibration is written through the APB port at byte address 8 * index
// and should only change while no sample is in flight. A zero pressure
// divisor gives pressure 0 with the flag in tuser.
`default_nettype none

module environmental_sensor_compensation_unit
    import escu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    // sample stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,  // adc_temp[19:0], adc_press[39:20], adc_hum[55:40]
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,  // temperature_centi[31:0], pressure_q24_8[63:32],
                                       // humidity_q7_10[80:64], zero[87:81]
    output logic [0:0]       m_tuser   // pressure_invalid[0]
);

    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] press;
        logic [16:0] hum;
        logic        invalid;
    } out_item_t;

    // ---------------- calibration registers ----------------
    logic [47:0] cal_t_reg;
    logic [63:0] cal_pl_reg;
    logic [63:0] cal_ph_reg;
    logic [15:0] cal_p9_reg;
    logic [39:0] cal_h_reg;
    logic [23:0] cal_hm_reg;
    logic [2:0]  cfg_idx;
    logic        cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_t_reg  <= '0;
            cal_pl_reg <= '0;
            cal_ph_reg <= '0;
            cal_p9_reg <= '0;
            cal_h_reg  <= '0;
            cal_hm_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_TEMP_CAL:   cal_t_reg  <= pwdata[47:0];
                REG_PRESS_LOW:  cal_pl_reg <= pwdata;
                REG_PRESS_HIGH: cal_ph_reg <= pwdata;
                REG_PRESS_LAST: cal_p9_reg <= pwdata[15:0];
                REG_HUM_CAL:    cal_h_reg  <= pwdata[39:0];
                REG_HUM_MID:    cal_hm_reg <= pwdata[23:0];
                default: ;      // unmapped, write dropped
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_TEMP_CAL:   prdata = {16'd0, cal_t_reg};
            REG_PRESS_LOW:  prdata = cal_pl_reg;
            REG_PRESS_HIGH: prdata = cal_ph_reg;
            REG_PRESS_LAST: prdata = {48'd0, cal_p9_reg};
            REG_HUM_CAL:    prdata = {24'd0, cal_h_reg};
            REG_HUM_MID:    prdata = {40'd0, cal_hm_reg};
            default:        prdata = '0;
        endcase
    end

    // ---------------- coefficients, sign-extended ----------------
    logic [31:0] t1, t2, t3;
    logic [63:0] p1, p3, p4, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;

    assign t1 = {16'd0, cal_t_reg[15:0]};
    assign t2 = {{16{cal_t_reg[31]}}, cal_t_reg[31:16]};
    assign t3 = {{16{cal_t_reg[47]}}, cal_t_reg[47:32]};

    assign p1 = {48'd0, cal_pl_reg[15:0]};
    assign p3 = {{48{cal_pl_reg[47]}}, cal_pl_reg[47:32]};
    assign p4 = {{48{cal_pl_reg[63]}}, cal_pl_reg[63:48]};
    assign p6 = {{48{cal_ph_reg[31]}}, cal_ph_reg[31:16]};
    assign p7 = {{48{cal_ph_reg[47]}}, cal_ph_reg[47:32]};
    assign p8 = {{48{cal_ph_reg[63]}}, cal_ph_reg[63:48]};
    assign p9 = {{48{cal_p9_reg[15]}}, cal_p9_reg};
    // P2 and P5 enter only through the narrow 34 x 16 products below

    assign h1 = {24'd0, cal_h_reg[7:0]};
    assign h2 = {{16{cal_h_reg[23]}}, cal_h_reg[23:8]};
    assign h3 = {24'd0, cal_h_reg[31:24]};
    assign h6 = {{24{cal_h_reg[39]}}, cal_h_reg[39:32]};
    assign h4 = {{20{cal_hm_reg[11]}}, cal_hm_reg[11:0]};
    assign h5 = {{20{cal_hm_reg[23]}}, cal_hm_reg[23:12]};

    // ---------------- pipeline control ----------------
    logic out_v_reg;
    logic skid_v_reg;
    logic en;

    // whole pipe moves together; the skid entry absorbs the one result
    // that can arrive after the output stalls
    assign en       = !skid_v_reg;
    assign s_tready = en;

    // ---------------- front stage registers ----------------
    logic        s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg;
    logic        s6_v_reg, s7_v_reg, s8_v_reg, s9_v_reg, s10_v_reg;
    logic        s11_v_reg, s12_v_reg, s13_v_reg, s14_v_reg, s15_v_reg;

    logic [31:0] s1_ta_reg, s1_d_reg;
    logic [20:0] s1_pp_reg, s2_pp_reg, s3_pp_reg, s4_pp_reg, s5_pp_reg;
    logic [20:0] s6_pp_reg, s7_pp_reg, s8_pp_reg, s9_pp_reg, s10_pp_reg;
    logic [15:0] s1_ah_reg, s2_ah_reg, s3_ah_reg, s4_ah_reg, s5_ah_reg, s6_ah_reg;
    logic [31:0] s2_aprod_reg, s2_dd_reg;
    logic [31:0] s3_a_reg, s3_b1_reg;
    logic [31:0] s4_fine_reg;
    logic [31:0] s5_temp_reg, s6_temp_reg, s7_temp_reg, s8_temp_reg, s9_temp_reg;
    logic [31:0] s10_temp_reg, s11_temp_reg, s12_temp_reg, s13_temp_reg, s14_temp_reg;
    logic [63:0] s5_v1_reg;
    logic [31:0] s5_x_reg;
    logic [31:0] s6_v1abs_reg;
    logic [63:0] s6_v1p5_reg, s7_v1p5_reg, s8_v1p5_reg, s9_v1p5_reg;
    logic [63:0] s6_v1p2_reg, s7_v1p2_reg, s8_v1p2_reg, s9_v1p2_reg;
    logic [31:0] s6_h5x_reg, s6_xh6_reg, s6_xh3_reg;
    logic [63:0] s7_v1sq_reg;
    logic [31:0] s7_y_reg, s8_y_reg, s9_y_reg, s10_y_reg;
    logic [31:0] s7_za_reg, s7_zb_reg;
    mul_part_t   s8_part6_reg, s8_part3_reg;
    logic [31:0] s8_z_reg;
    logic [63:0] s9_m6_reg, s9_m3_reg;
    logic [31:0] s9_z2_reg;
    logic [63:0] s10_v2_reg, s10_v1b_reg;
    logic [31:0] s10_z3_reg;
    mul_part_t   s11_partp1_reg;
    logic [63:0] s11_dv_reg;
    logic [31:0] s11_hx_reg, s12_hx_reg, s13_hx_reg, s14_hx_reg;
    logic [30:0] s12_den_reg, s13_den_reg;
    mul_part_t   s12_partn_reg;
    logic [31:0] s12_hy_reg;
    logic [63:0] s13_num_reg;
    logic [31:0] s13_hyy_reg;
    logic [63:0] s14_nabs_reg, s15_nabs_reg;
    logic [30:0] s14_dabs_reg, s15_dabs_reg;
    logic        s14_neg_reg, s14_inv_reg;
    logic [31:0] s14_hh_reg;
    div_side_t   s15_side_reg;

    logic [19:0] adc_temp, adc_press;
    logic [15:0] adc_hum;
    logic [63:0] s12_prod;
    logic [31:0] hum_fin;
    logic [16:0] hum_next;

    assign adc_temp  = s_tdata[19:0];
    assign adc_press = s_tdata[39:20];
    assign adc_hum   = s_tdata[55:40];
    assign s12_prod  = mul_join(s11_partp1_reg);

    // humidity: remove the quadratic term, clamp to 0..100 %, drop 12 bits
    always_comb
    begin
        hum_fin = s14_hx_reg - asr32(s14_hh_reg, 4);
        if (hum_fin[31])
        begin
            hum_next = '0;
        end
        else if (hum_fin > 32'd419430400)
        begin
            hum_next = 17'd102400;
        end
        else
        begin
            hum_next = hum_fin[28:12];
        end
    end

    // ---------------- post-divide stage registers ----------------
    logic        div_v;
    logic [63:0] div_quo;
    div_side_t   div_side;

    logic        q1_v_reg, q2_v_reg, q3_v_reg, q4_v_reg, q5_v_reg;
    logic [63:0] q1_q_reg, q2_q_reg, q3_q_reg, q4_q_reg, q5_q_reg;
    div_side_t   q1_side_reg, q2_side_reg, q3_side_reg, q4_side_reg, q5_side_reg;
    logic [63:0] q2_q13_reg, q3_q13_reg;
    mul_part_t   q2_parta_reg, q2_part8_reg;
    logic [63:0] q3_m9_reg, q3_m8_reg;
    mul_part_t   q4_partb_reg;
    logic [63:0] q4_v2p_reg, q5_v2p_reg;
    logic [63:0] q5_v1p_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0; s2_v_reg  <= 1'b0; s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0; s5_v_reg  <= 1'b0; s6_v_reg  <= 1'b0;
            s7_v_reg  <= 1'b0; s8_v_reg  <= 1'b0; s9_v_reg  <= 1'b0;
            s10_v_reg <= 1'b0; s11_v_reg <= 1'b0; s12_v_reg <= 1'b0;
            s13_v_reg <= 1'b0; s14_v_reg <= 1'b0; s15_v_reg <= 1'b0;
            q1_v_reg  <= 1'b0; q2_v_reg  <= 1'b0; q3_v_reg  <= 1'b0;
            q4_v_reg  <= 1'b0; q5_v_reg  <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg  <= s_tvalid;  s2_v_reg  <= s1_v_reg;  s3_v_reg  <= s2_v_reg;
            s4_v_reg  <= s3_v_reg;  s5_v_reg  <= s4_v_reg;  s6_v_reg  <= s5_v_reg;
            s7_v_reg  <= s6_v_reg;  s8_v_reg  <= s7_v_reg;  s9_v_reg  <= s8_v_reg;
            s10_v_reg <= s9_v_reg;  s11_v_reg <= s10_v_reg; s12_v_reg <= s11_v_reg;
            s13_v_reg <= s12_v_reg; s14_v_reg <= s13_v_reg; s15_v_reg <= s14_v_reg;
            q1_v_reg  <= div_v;     q2_v_reg  <= q1_v_reg;  q3_v_reg  <= q2_v_reg;
            q4_v_reg  <= q3_v_reg;  q5_v_reg  <= q4_v_reg;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // S1: temperature offsets, pressure count from full scale
            s1_ta_reg <= {15'd0, adc_temp[19:3]} - {t1[30:0], 1'b0};
            s1_d_reg  <= {16'd0, adc_temp[19:4]} - t1;
            s1_pp_reg <= 21'd1048576 - {1'b0, adc_press};
            s1_ah_reg <= adc_hum;

            // S2
            s2_aprod_reg <= s1_ta_reg * t2;
            s2_dd_reg    <= s1_d_reg * s1_d_reg;
            s2_pp_reg    <= s1_pp_reg;
            s2_ah_reg    <= s1_ah_reg;

            // S3
            s3_a_reg  <= asr32(s2_aprod_reg, 11);
            s3_b1_reg <= asr32(s2_dd_reg, 12) * t3;
            s3_pp_reg <= s2_pp_reg;
            s3_ah_reg <= s2_ah_reg;

            // S4: fine temperature
            s4_fine_reg <= s3_a_reg + asr32(s3_b1_reg, 14);
            s4_pp_reg   <= s3_pp_reg;
            s4_ah_reg   <= s3_ah_reg;

            // S5: temperature result, pressure and humidity offsets
            s5_temp_reg <= asr32({s4_fine_reg[29:0], 2'b00} + s4_fine_reg + 32'd128, 8);
            s5_v1_reg   <= {{32{s4_fine_reg[31]}}, s4_fine_reg} - 64'd128000;
            s5_x_reg    <= s4_fine_reg - 32'd76800;
            s5_pp_reg   <= s4_pp_reg;
            s5_ah_reg   <= s4_ah_reg;

            // S6: v1 fits 34 bits signed, its magnitude 32 bits
            s6_temp_reg  <= s5_temp_reg;
            s6_v1abs_reg <= s5_v1_reg[63] ? 32'(64'd0 - s5_v1_reg) : s5_v1_reg[31:0];
            s6_v1p5_reg  <= mul_s34x16(s5_v1_reg[33:0], cal_ph_reg[15:0]);
            s6_v1p2_reg  <= mul_s34x16(s5_v1_reg[33:0], cal_pl_reg[31:16]);
            s6_h5x_reg   <= h5 * s5_x_reg;
            s6_xh6_reg   <= s5_x_reg * h6;
            s6_xh3_reg   <= s5_x_reg * h3;
            s6_pp_reg    <= s5_pp_reg;
            s6_ah_reg    <= s5_ah_reg;

            // S7
            s7_temp_reg <= s6_temp_reg;
            s7_v1sq_reg <= {32'd0, s6_v1abs_reg} * {32'd0, s6_v1abs_reg};
            s7_v1p5_reg <= s6_v1p5_reg;
            s7_v1p2_reg <= s6_v1p2_reg;
            s7_y_reg    <= asr32({2'd0, s6_ah_reg, 14'd0} - {h4[11:0], 20'd0}
                                 - s6_h5x_reg + 32'd16384, 15);
            s7_za_reg   <= asr32(s6_xh6_reg, 10);
            s7_zb_reg   <= asr32(s6_xh3_reg, 11) + 32'd32768;
            s7_pp_reg   <= s6_pp_reg;

            // S8
            s8_temp_reg  <= s7_temp_reg;
            s8_part6_reg <= mul_part(s7_v1sq_reg, p6);
            s8_part3_reg <= mul_part(s7_v1sq_reg, p3);
            s8_v1p5_reg  <= s7_v1p5_reg;
            s8_v1p2_reg  <= s7_v1p2_reg;
            s8_y_reg     <= s7_y_reg;
            s8_z_reg     <= s7_za_reg * s7_zb_reg;
            s8_pp_reg    <= s7_pp_reg;

            // S9
            s9_temp_reg <= s8_temp_reg;
            s9_m6_reg   <= mul_join(s8_part6_reg);
            s9_m3_reg   <= mul_join(s8_part3_reg);
            s9_v1p5_reg <= s8_v1p5_reg;
            s9_v1p2_reg <= s8_v1p2_reg;
            s9_y_reg    <= s8_y_reg;
            s9_z2_reg   <= (asr32(s8_z_reg, 10) + 32'd2097152) * h2;
            s9_pp_reg   <= s8_pp_reg;

            // S10: assemble v2 and the divisor seed
            s10_temp_reg <= s9_temp_reg;
            s10_v2_reg   <= s9_m6_reg + {s9_v1p5_reg[46:0], 17'd0} + {p4[28:0], 35'd0};
            s10_v1b_reg  <= asr64(s9_m3_reg, 8) + {s9_v1p2_reg[51:0], 12'd0}
                            + 64'd140737488355328;
            s10_y_reg    <= s9_y_reg;
            s10_z3_reg   <= asr32(s9_z2_reg + 32'd8192, 14);
            s10_pp_reg   <= s9_pp_reg;

            // S11
            s11_temp_reg   <= s10_temp_reg;
            s11_partp1_reg <= mul_part(s10_v1b_reg, p1);
            s11_dv_reg     <= {12'd0, s10_pp_reg, 31'd0} - s10_v2_reg;
            s11_hx_reg     <= s10_y_reg * s10_z3_reg;

            // S12: divisor is the product shifted down 33, 31 bits signed
            s12_temp_reg  <= s11_temp_reg;
            s12_den_reg   <= s12_prod[63:33];
            s12_partn_reg <= mul_part(s11_dv_reg, 64'd3125);
            s12_hx_reg    <= s11_hx_reg;
            s12_hy_reg    <= asr32(s11_hx_reg, 15);

            // S13
            s13_temp_reg <= s12_temp_reg;
            s13_den_reg  <= s12_den_reg;
            s13_num_reg  <= mul_join(s12_partn_reg);
            s13_hx_reg   <= s12_hx_reg;
            s13_hyy_reg  <= s12_hy_reg * s12_hy_reg;

            // S14: magnitudes and quotient sign for the divider
            s14_temp_reg <= s13_temp_reg;
            s14_nabs_reg <= s13_num_reg[63] ? 64'd0 - s13_num_reg : s13_num_reg;
            s14_dabs_reg <= s13_den_reg[30] ? 31'd0 - s13_den_reg : s13_den_reg;
            s14_neg_reg  <= s13_num_reg[63] ^ s13_den_reg[30];
            s14_inv_reg  <= (s13_den_reg == 31'd0);
            s14_hx_reg   <= s13_hx_reg;
            s14_hh_reg   <= asr32(s13_hyy_reg, 7) * h1;

            // S15
            s15_nabs_reg         <= s14_nabs_reg;
            s15_dabs_reg         <= s14_dabs_reg;
            s15_side_reg.temp    <= s14_temp_reg;
            s15_side_reg.hum     <= hum_next;
            s15_side_reg.neg     <= s14_neg_reg;
            s15_side_reg.invalid <= s14_inv_reg;

            // after the divider: restore sign, then P9 and P8 corrections
            q1_q_reg    <= div_side.neg ? 64'd0 - div_quo : div_quo;
            q1_side_reg <= div_side;

            q2_q_reg     <= q1_q_reg;
            q2_q13_reg   <= asr64(q1_q_reg, 13);
            q2_parta_reg <= mul_part(p9, asr64(q1_q_reg, 13));
            q2_part8_reg <= mul_part(p8, q1_q_reg);
            q2_side_reg  <= q1_side_reg;

            q3_q_reg    <= q2_q_reg;
            q3_q13_reg  <= q2_q13_reg;
            q3_m9_reg   <= mul_join(q2_parta_reg);
            q3_m8_reg   <= mul_join(q2_part8_reg);
            q3_side_reg <= q2_side_reg;

            q4_q_reg     <= q3_q_reg;
            q4_partb_reg <= mul_part(q3_m9_reg, q3_q13_reg);
            q4_v2p_reg   <= asr64(q3_m8_reg, 19);
            q4_side_reg  <= q3_side_reg;

            q5_q_reg    <= q4_q_reg;
            q5_v1p_reg  <= asr64(mul_join(q4_partb_reg), 25);
            q5_v2p_reg  <= q4_v2p_reg;
            q5_side_reg <= q4_side_reg;
        end
    end

    escu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s15_v_reg),
        .in_num   (s15_nabs_reg),
        .in_den   (s15_dabs_reg),
        .in_side  (s15_side_reg),
        .out_valid(div_v),
        .out_quo  (div_quo),
        .out_side (div_side)
    );

    // ---------------- final sum and output buffering ----------------
    logic [63:0] press_sum;
    out_item_t   fin;
    out_item_t   out_reg;
    out_item_t   skid_reg;
    logic        load;

    assign press_sum   = asr64(q5_q_reg + q5_v1p_reg + q5_v2p_reg, 8) + {p7[59:0], 4'd0};
    assign fin.temp    = q5_side_reg.temp;
    assign fin.press   = q5_side_reg.invalid ? 32'd0 : press_sum[31:0];
    assign fin.hum     = q5_side_reg.hum;
    assign fin.invalid = q5_side_reg.invalid;
    assign load        = en & q5_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (out_v_reg && m_tready)
        begin
            if (skid_v_reg)
            begin
                out_reg    <= skid_reg;
                skid_v_reg <= 1'b0;
            end
            else if (load)
            begin
                out_reg <= fin;
            end
            else
            begin
                out_v_reg <= 1'b0;
            end
        end
        else if (!out_v_reg)
        begin
            if (load)
            begin
                out_reg   <= fin;
                out_v_reg <= 1'b1;
            end
        end
        else if (load)
        begin
            // output stalled: park the arriving result
            skid_reg   <= fin;
            skid_v_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {7'd0, out_reg.hum, out_reg.press, out_reg.temp};
    assign m_tuser  = out_reg.invalid;

`ifndef ASSERT_OFF
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid entry held while output empty");

    a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_v_reg) |-> $past(out_v_reg && !m_tready))
        else $error("skid entry filled without an output stall");

    a_invalid_zero_press: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[63:32] == 32'd0))
        else $error("invalid pressure result not zero");
`endif

endmodule

`default_nettype wire
